// ===== src/wtnm_pkg.sv =====
package wtnm_pkg;

  // Table geometry
  localparam int unsigned EntryW   = 6;
  localparam int unsigned EntryCntW = EntryW + 1;
  localparam int unsigned ContourW = 2;
  localparam int unsigned PosW     = 6;
  localparam int unsigned ElemW    = ContourW + PosW;
  localparam int unsigned TplAddrW = EntryW + ElemW;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned SymbolW  = 8;
  localparam int unsigned CountW   = 3;
  localparam int unsigned DistW    = 42;
  localparam int unsigned SqW      = 32;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [EntryCntW-1:0] ENTRIES   = 7'd64;
  localparam logic [PosW-1:0]      MAX_PAIRS = 6'd32;

  localparam logic [DistW-1:0] DIST_MAX = {DistW{1'b1}};

  // Reset values of the configuration registers
  localparam logic [PosW-1:0]      DESC_RST  = 6'd32;
  localparam logic [EntryW-1:0]    FIRST_RST = 6'd0;
  localparam logic [EntryCntW-1:0] END_RST   = 7'd64;

  typedef enum logic [1:0] {
    CMD_HDR   = 2'd0,
    CMD_TPL   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_RUN   = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DESC_COUNT  = 2'd0,
    CFG_FIRST_ENTRY = 2'd1,
    CFG_END_ENTRY   = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_CHECK,
    S_ELEM,
    S_DRAIN,
    S_CMP,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic                wr_hdr;
    logic                wr_tpl;
    logic                wr_qry;
    logic                run_start;
    logic                hdr_rd;
    logic                elem_rd;
    logic [EntryW-1:0]   entry;
    logic [ContourW-1:0] contour;
    logic [PosW-1:0]     pos;
    logic                acc_clr;
    logic                cmp;
    logic                res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic                skip;
    logic [ContourW-1:0] last_c;
    logic                pipe_busy;
    logic                out_free;
  } dp_stat_t;

endpackage

// ===== src/wtnm_dp.sv =====
module wtnm_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wtnm_pkg::dp_cmd_t                  cmd_i,
  output wtnm_pkg::dp_stat_t                 stat_o,
  input  logic        [wtnm_pkg::EntryW-1:0] entry_i,
  input  logic        [wtnm_pkg::ElemW-1:0]  elem_i,
  input  logic signed [wtnm_pkg::ValueW-1:0] value_i,
  input  logic       [wtnm_pkg::SymbolW-1:0] symbol_i,
  input  logic signed [wtnm_pkg::CountW-1:0] contours_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic       [wtnm_pkg::SymbolW-1:0] best_symbol_o,
  output logic        [wtnm_pkg::EntryW-1:0] best_entry_o,
  output logic                               found_o,
  output logic         [wtnm_pkg::DistW-1:0] distance_o
);

  localparam int unsigned Entries  = 2 ** wtnm_pkg::EntryW;
  localparam int unsigned TplDepth = 2 ** wtnm_pkg::TplAddrW;
  localparam int unsigned QryDepth = 2 ** wtnm_pkg::ElemW;

  logic [wtnm_pkg::SymbolW-1:0] sym_mem [Entries];
  logic [wtnm_pkg::CountW-1:0]  cnt_mem [Entries];
  logic [wtnm_pkg::ValueW-1:0]  tpl_mem [TplDepth];
  logic [wtnm_pkg::ValueW-1:0]  qry_mem [QryDepth];

  logic [wtnm_pkg::SymbolW-1:0] hdr_sym_q;
  logic [wtnm_pkg::CountW-1:0]  hdr_cnt_q;
  logic [wtnm_pkg::CountW-1:0]  qcnt_q;
  logic [wtnm_pkg::EntryW-1:0]  cur_entry_q;

  logic signed [wtnm_pkg::ValueW-1:0] t_rd_q, q_rd_q;
  logic signed [wtnm_pkg::ValueW:0]   diff_d, diff_q;
  logic signed [2*wtnm_pkg::ValueW+1:0] prod;
  logic [wtnm_pkg::SqW-1:0]   sq_q;
  logic [wtnm_pkg::SqW+1:0]   sq3;
  logic [wtnm_pkg::DistW-1:0] acc_d, acc_q;
  logic v1_q, v2_q, v3_q, w1_q, w2_q, w3_q;

  logic [wtnm_pkg::DistW-1:0]   best_q;
  logic [wtnm_pkg::EntryW-1:0]  best_e_q;
  logic [wtnm_pkg::SymbolW-1:0] best_sym_q;
  logic                         found_q;
  logic                         out_valid_q;

  // Header and element stores: one write port for loads, one read port for the search
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_hdr) begin
      sym_mem[entry_i] <= symbol_i;
      cnt_mem[entry_i] <= contours_i;
    end
    if (cmd_i.hdr_rd) begin
      hdr_sym_q <= sym_mem[cmd_i.entry];
      hdr_cnt_q <= cnt_mem[cmd_i.entry];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_tpl) begin
      tpl_mem[{entry_i, elem_i}] <= value_i;
    end
    if (cmd_i.elem_rd) begin
      t_rd_q <= tpl_mem[{cmd_i.entry, cmd_i.contour, cmd_i.pos}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_qry) begin
      qry_mem[elem_i] <= value_i;
    end
    if (cmd_i.elem_rd) begin
      q_rd_q <= qry_mem[{cmd_i.contour, cmd_i.pos}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_start) begin
      qcnt_q <= contours_i;
    end
    if (cmd_i.hdr_rd) begin
      cur_entry_q <= cmd_i.entry;
    end
  end

  // A negative template count means unchecked: outer contour only
  assign stat_o.skip   = !hdr_cnt_q[wtnm_pkg::CountW-1] && (hdr_cnt_q != qcnt_q);
  assign stat_o.last_c = hdr_cnt_q[wtnm_pkg::CountW-1] ? '0
                                                        : hdr_cnt_q[wtnm_pkg::ContourW-1:0];

  // Difference and square, one stage each; weight and accumulate share the last stage
  assign diff_d = {t_rd_q[wtnm_pkg::ValueW-1], t_rd_q} - {q_rd_q[wtnm_pkg::ValueW-1], q_rd_q};
  assign prod   = diff_q * diff_q;
  assign sq3    = {2'b00, sq_q} + {1'b0, sq_q, 1'b0};

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.acc_clr) begin
      acc_d = '0;
    end else if (v3_q) begin
      if (w3_q) begin
        acc_d = acc_q + {{(wtnm_pkg::DistW-wtnm_pkg::SqW){1'b0}}, sq_q};
      end else begin
        acc_d = acc_q + {{(wtnm_pkg::DistW-wtnm_pkg::SqW-2){1'b0}}, sq3};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
    sq_q   <= prod[wtnm_pkg::SqW-1:0];
    acc_q  <= acc_d;
    w1_q   <= cmd_i.pos[0];
    w2_q   <= w1_q;
    w3_q   <= w2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.elem_rd;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign stat_o.pipe_busy = v1_q || v2_q || v3_q;

  // Running best; strict compare keeps the lower entry on a tie
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.run_start) begin
      found_q <= 1'b0;
    end else if (cmd_i.cmp && (acc_q < best_q)) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_start) begin
      best_q     <= wtnm_pkg::DIST_MAX;
      best_e_q   <= '0;
      best_sym_q <= '0;
    end else if (cmd_i.cmp && (acc_q < best_q)) begin
      best_q     <= acc_q;
      best_e_q   <= cur_entry_q;
      best_sym_q <= hdr_sym_q;
    end
  end

  // Output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      best_symbol_o <= best_sym_q;
      best_entry_o  <= best_e_q;
      found_o       <= found_q;
      distance_o    <= best_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> !(out_valid_q && out_stall_i))
    else $error("result word overwritten while stalled");

  a_drained_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cmp |-> !(v1_q || v2_q || v3_q))
    else $error("entry compared before its sum was complete");

endmodule

// ===== src/wtnm_ctrl.sv =====
module wtnm_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                          [1:0] cmd_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic      [wtnm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic      [wtnm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wtnm_pkg::dp_stat_t                  stat_i,
  output wtnm_pkg::dp_cmd_t                   cmd_o
);

  wtnm_pkg::state_e state_q, state_d;

  logic [wtnm_pkg::PosW-1:0]      desc_q;
  logic [wtnm_pkg::EntryW-1:0]    first_q;
  logic [wtnm_pkg::EntryCntW-1:0] end_q;

  logic [wtnm_pkg::EntryCntW-1:0] e_q, e_d, e_nxt, end_sat;
  logic [wtnm_pkg::ContourW-1:0]  c_q, c_d, lastc_q, lastc_d;
  logic [wtnm_pkg::PosW-1:0]      p_q, p_d, pairs;
  logic [wtnm_pkg::PosW:0]        positions;
  logic                           accept, last_pos, range_done;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      desc_q  <= wtnm_pkg::DESC_RST;
      first_q <= wtnm_pkg::FIRST_RST;
      end_q   <= wtnm_pkg::END_RST;
    end else if (cfg_valid_i) begin
      unique case (wtnm_pkg::cfg_idx_e'(cfg_index_i))
        wtnm_pkg::CFG_DESC_COUNT:  desc_q  <= cfg_data_i[wtnm_pkg::PosW-1:0];
        wtnm_pkg::CFG_FIRST_ENTRY: first_q <= cfg_data_i[wtnm_pkg::EntryW-1:0];
        wtnm_pkg::CFG_END_ENTRY:   end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign pairs      = (desc_q > wtnm_pkg::MAX_PAIRS) ? wtnm_pkg::MAX_PAIRS : desc_q;
  assign positions  = {pairs, 1'b0};
  assign end_sat    = (end_q > wtnm_pkg::ENTRIES) ? wtnm_pkg::ENTRIES : end_q;
  assign e_nxt      = e_q + 1'b1;
  assign range_done = (e_nxt >= end_sat);
  assign last_pos   = (({1'b0, p_q} + 1'b1) == positions);

  assign in_stall_o = (state_q != wtnm_pkg::S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wtnm_pkg::S_IDLE;
      e_q     <= '0;
      c_q     <= '0;
      p_q     <= '0;
      lastc_q <= '0;
    end else begin
      state_q <= state_d;
      e_q     <= e_d;
      c_q     <= c_d;
      p_q     <= p_d;
      lastc_q <= lastc_d;
    end
  end

  always_comb begin
    state_d = state_q;
    e_d     = e_q;
    c_d     = c_q;
    p_d     = p_q;
    lastc_d = lastc_q;

    cmd_o           = '0;
    cmd_o.entry     = e_q[wtnm_pkg::EntryW-1:0];
    cmd_o.contour   = c_q;
    cmd_o.pos       = p_q;

    unique case (state_q)
      wtnm_pkg::S_IDLE: begin
        if (accept) begin
          unique case (wtnm_pkg::cmd_e'(cmd_i))
            wtnm_pkg::CMD_HDR:   cmd_o.wr_hdr = 1'b1;
            wtnm_pkg::CMD_TPL:   cmd_o.wr_tpl = 1'b1;
            wtnm_pkg::CMD_QUERY: cmd_o.wr_qry = 1'b1;
            wtnm_pkg::CMD_RUN: begin
              cmd_o.run_start = 1'b1;
              e_d = {1'b0, first_q};
              if ({1'b0, first_q} >= end_sat) begin
                state_d = wtnm_pkg::S_RESULT;
              end else begin
                state_d = wtnm_pkg::S_HDR;
              end
            end
            default: ;
          endcase
        end
      end
      wtnm_pkg::S_HDR: begin
        cmd_o.hdr_rd  = 1'b1;
        cmd_o.acc_clr = 1'b1;
        state_d = wtnm_pkg::S_CHECK;
      end
      wtnm_pkg::S_CHECK: begin
        if (stat_i.skip) begin
          e_d = e_nxt;
          state_d = range_done ? wtnm_pkg::S_RESULT : wtnm_pkg::S_HDR;
        end else begin
          c_d     = '0;
          p_d     = '0;
          lastc_d = stat_i.last_c;
          state_d = (positions == '0) ? wtnm_pkg::S_DRAIN : wtnm_pkg::S_ELEM;
        end
      end
      wtnm_pkg::S_ELEM: begin
        cmd_o.elem_rd = 1'b1;
        if (last_pos) begin
          p_d = '0;
          if (c_q == lastc_q) begin
            state_d = wtnm_pkg::S_DRAIN;
          end else begin
            c_d = c_q + 1'b1;
          end
        end else begin
          p_d = p_q + 1'b1;
        end
      end
      wtnm_pkg::S_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = wtnm_pkg::S_CMP;
        end
      end
      wtnm_pkg::S_CMP: begin
        cmd_o.cmp = 1'b1;
        e_d = e_nxt;
        state_d = range_done ? wtnm_pkg::S_RESULT : wtnm_pkg::S_HDR;
      end
      wtnm_pkg::S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d = wtnm_pkg::S_IDLE;
        end
      end
      default: state_d = wtnm_pkg::S_IDLE;
    endcase
  end

  a_entry_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wtnm_pkg::S_HDR) |-> (e_q < end_sat))
    else $error("search visited an entry outside the range");

  a_elem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.elem_rd |-> (({1'b0, p_q} < positions) && (c_q <= lastc_q)))
    else $error("element read beyond the compared positions");

endmodule

// ===== src/weighted_template_nearest_match.sv =====
// Nearest-template classifier. Words with cmd 0/1/2 load a template header, a template
// element or a query element; cmd 3 searches entries first_entry .. end_entry-1 and
// returns one result word. Words are taken only while the block is idle. A search reads
// the header of each entry in the range and, for each entry that is not skipped,
// 2*pairs elements per compared contour, where pairs = min(desc_count, 32): the single
// read port of the template store gives one element a cycle. The result sits in an
// output register, so loads go on while it waits to be taken; a further search holds
// its result until that register is free.
module weighted_template_nearest_match (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                           [1:0] cmd_i,
  input  logic        [wtnm_pkg::EntryW-1:0]   entry_i,
  input  logic        [wtnm_pkg::ElemW-1:0]    elem_i,
  input  logic signed [wtnm_pkg::ValueW-1:0]   value_i,
  input  logic        [wtnm_pkg::SymbolW-1:0]  symbol_i,
  input  logic signed [wtnm_pkg::CountW-1:0]   contours_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic        [wtnm_pkg::SymbolW-1:0]  best_symbol_o,
  output logic        [wtnm_pkg::EntryW-1:0]   best_entry_o,
  output logic                                 found_o,
  output logic        [wtnm_pkg::DistW-1:0]    distance_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic        [wtnm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic        [wtnm_pkg::CfgDataW-1:0] cfg_data_i
);

  wtnm_pkg::dp_cmd_t  dp_cmd;
  wtnm_pkg::dp_stat_t dp_stat;

  wtnm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  wtnm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .entry_i       (entry_i),
    .elem_i        (elem_i),
    .value_i       (value_i),
    .symbol_i      (symbol_i),
    .contours_i    (contours_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .best_symbol_o (best_symbol_o),
    .best_entry_o  (best_entry_o),
    .found_o       (found_o),
    .distance_o    (distance_o)
  );

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [wtnm_pkg::SymbolW-1:0] sym;
    logic [wtnm_pkg::EntryW-1:0]  ent;
    logic                         hit;
    logic [wtnm_pkg::DistW-1:0]   sq_dist;
  } outcome_t;

  // Holds a copy of the template store and the search registers, and keeps
  // the outcome of every accepted search until its result word comes back.
  class nearest_scoreboard;
    logic [wtnm_pkg::SymbolW-1:0]       sym_mem [64];
    logic signed [wtnm_pkg::CountW-1:0] cnt_mem [64];
    logic signed [wtnm_pkg::ValueW-1:0] tpl_mem [16384];
    logic signed [wtnm_pkg::ValueW-1:0] qry_mem [256];
    logic [wtnm_pkg::PosW-1:0]          desc_r;
    logic [wtnm_pkg::EntryW-1:0]        first_r;
    logic [wtnm_pkg::EntryCntW-1:0]     end_r;
    outcome_t                           outcome_q [$];
    int                                 errors;
    int                                 searches;
    int                                 hits;

    function new();
      desc_r   = wtnm_pkg::DESC_RST;
      first_r  = wtnm_pkg::FIRST_RST;
      end_r    = wtnm_pkg::END_RST;
      errors   = 0;
      searches = 0;
      hits     = 0;
    endfunction

    function void write_reg(wtnm_pkg::cfg_idx_e idx, logic [wtnm_pkg::CfgDataW-1:0] data);
      case (idx)
        wtnm_pkg::CFG_DESC_COUNT:  desc_r = data[wtnm_pkg::PosW-1:0];
        wtnm_pkg::CFG_FIRST_ENTRY: first_r = data[wtnm_pkg::EntryW-1:0];
        wtnm_pkg::CFG_END_ENTRY:   end_r = data;
        default: ;
      endcase
    endfunction

    function int num_positions();
      return 2 * int'(desc_r > wtnm_pkg::MAX_PAIRS ? wtnm_pkg::MAX_PAIRS : desc_r);
    endfunction

    function int stop_entry();
      return int'(end_r > wtnm_pkg::ENTRIES ? wtnm_pkg::ENTRIES : end_r);
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    function void note_word(wtnm_pkg::cmd_e cmd, logic [wtnm_pkg::EntryW-1:0] entry,
                            logic [wtnm_pkg::ElemW-1:0] elem,
                            logic signed [wtnm_pkg::ValueW-1:0] value,
                            logic [wtnm_pkg::SymbolW-1:0] symbol,
                            logic signed [wtnm_pkg::CountW-1:0] contours);
      outcome_t    res;
      u64_t        acc;
      longint      diff;
      int          last_c;
      int          npos;
      case (cmd)
        wtnm_pkg::CMD_HDR: begin
          sym_mem[entry] = symbol;
          cnt_mem[entry] = contours;
        end
        wtnm_pkg::CMD_TPL:   tpl_mem[{entry, elem}] = value;
        wtnm_pkg::CMD_QUERY: qry_mem[elem] = value;
        default: begin
          npos        = num_positions();
          res.sym     = '0;
          res.ent     = '0;
          res.hit     = 1'b0;
          res.sq_dist = wtnm_pkg::DIST_MAX;
          for (int e = int'(first_r); e < stop_entry(); e++) begin
            // unchecked templates compare the outer contour only
            if (cnt_mem[e] < 0) last_c = 0;
            else if (cnt_mem[e] != contours) continue;
            else last_c = int'(cnt_mem[e]);
            acc = 0;
            for (int c = 0; c <= last_c; c++) begin
              for (int p = 0; p < npos; p++) begin
                diff = longint'(tpl_mem[e * 256 + c * 64 + p]) - longint'(qry_mem[c * 64 + p]);
                acc += (p % 2 == 1) ? u64_t'(diff * diff) : 3 * u64_t'(diff * diff);
              end
            end
            // strictly smaller only: ties stay with the lower entry
            if (acc < u64_t'(res.sq_dist)) begin
              res.sym     = sym_mem[e];
              res.ent     = wtnm_pkg::EntryW'(e);
              res.hit     = 1'b1;
              res.sq_dist = wtnm_pkg::DistW'(acc);
            end
          end
          outcome_q = {outcome_q, res};
          searches++;
          if (res.hit) hits++;
        end
      endcase
    endfunction

    function void check(outcome_t got);
      outcome_t want;
      if (outcome_q.size() == 0) begin
        errors++;
        $error("result word with no search outstanding");
        return;
      end
      want = outcome_q.pop_front();
      if (got.sym !== want.sym) begin
        errors++;
        $error("best_symbol: expected %0d, got %0d", want.sym, got.sym);
      end
      if (got.ent !== want.ent) begin
        errors++;
        $error("best_entry: expected %0d, got %0d", want.ent, got.ent);
      end
      if (got.hit !== want.hit) begin
        errors++;
        $error("found: expected %0d, got %0d", want.hit, got.hit);
      end
      if (got.sq_dist !== want.sq_dist) begin
        errors++;
        $error("distance: expected %0d, got %0d", want.sq_dist, got.sq_dist);
      end
    endfunction
  endclass

  localparam int NPH = 12;
  localparam int PH_DESC  [NPH] = '{1, 0, 66, 3, 2, 4, 5, 2, 1, 1, 2, 1};
  localparam int PH_FIRST [NPH] = '{0, 5, 0, 62, 63, 40, 0, 0, 0, 60, 8, 2};
  localparam int PH_END   [NPH] = '{4, 9, 3, 64, 127, 30, 0, 6, 9, 64, 12, 5};
  localparam int PH_RUNS  [NPH] = '{2, 1, 2, 2, 2, 1, 1, 3, 2, 2, 2, 2};

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_stall_o;
  logic [1:0]                         cmd_i;
  logic [wtnm_pkg::EntryW-1:0]        entry_i;
  logic [wtnm_pkg::ElemW-1:0]         elem_i;
  logic signed [wtnm_pkg::ValueW-1:0] value_i;
  logic [wtnm_pkg::SymbolW-1:0]       symbol_i;
  logic signed [wtnm_pkg::CountW-1:0] contours_i;
  logic                               out_valid_o;
  logic                               out_stall_i;
  logic [wtnm_pkg::SymbolW-1:0]       best_symbol_o;
  logic [wtnm_pkg::EntryW-1:0]        best_entry_o;
  logic                               found_o;
  logic [wtnm_pkg::DistW-1:0]         distance_o;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [wtnm_pkg::CfgIdxW-1:0]       cfg_index_i;
  logic [wtnm_pkg::CfgDataW-1:0]      cfg_data_i;

  nearest_scoreboard sb = new();

  bit hdr_wr [64];
  bit tpl_wr [16384];
  bit qry_wr [256];
  bit busy_phase = 1'b1;
  bit calm       = 1'b0;
  bit flat       = 1'b0;
  bit hold_req   = 1'b0;
  int loads      = 0;

  weighted_template_nearest_match u_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic signed [wtnm_pkg::ValueW-1:0] fill_value();
    if (flat) return 16'sd100;
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      3, 4, 5: return 16'(int'($urandom_range(0, 400)) - 200);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(wtnm_pkg::cmd_e cmd, logic [wtnm_pkg::EntryW-1:0] entry,
                           logic [wtnm_pkg::ElemW-1:0] elem,
                           logic signed [wtnm_pkg::ValueW-1:0] value,
                           logic [wtnm_pkg::SymbolW-1:0] symbol,
                           logic signed [wtnm_pkg::CountW-1:0] contours);
    if (!calm && busy_phase && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    entry_i    <= entry;
    elem_i     <= elem;
    value_i    <= value;
    symbol_i   <= symbol;
    contours_i <= contours;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_word(cmd, entry, elem, value, symbol, contours);
    case (cmd)
      wtnm_pkg::CMD_HDR:   hdr_wr[entry] = 1'b1;
      wtnm_pkg::CMD_TPL:   tpl_wr[{entry, elem}] = 1'b1;
      wtnm_pkg::CMD_QUERY: qry_wr[elem] = 1'b1;
      default: ;
    endcase
    if (cmd != wtnm_pkg::CMD_RUN) loads++;
  endtask

  task automatic cfg_write(wtnm_pkg::cfg_idx_e idx, logic [wtnm_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    // leave the block well clear
    repeat (16) @(negedge clk_i);
  endtask

  task automatic set_regs(logic [wtnm_pkg::CfgDataW-1:0] desc,
                          logic [wtnm_pkg::CfgDataW-1:0] lo,
                          logic [wtnm_pkg::CfgDataW-1:0] hi);
    wait_idle();
    cfg_write(wtnm_pkg::CFG_DESC_COUNT, desc);
    cfg_write(wtnm_pkg::CFG_FIRST_ENTRY, lo);
    cfg_write(wtnm_pkg::CFG_END_ENTRY, hi);
  endtask

  // Random load, mostly aimed at entries and positions the next search reads.
  task automatic noise_word();
    int                          lo;
    int                          hi;
    int                          npos;
    logic [wtnm_pkg::EntryW-1:0] ent;
    logic [wtnm_pkg::ElemW-1:0]  el;
    lo   = int'(sb.first_r);
    hi   = sb.stop_entry();
    npos = sb.num_positions();
    ent  = 6'($urandom);
    el   = 8'($urandom);
    if (hi > lo && $urandom_range(0, 4) != 0) ent = 6'($urandom_range(lo, hi - 1));
    if (npos > 0 && $urandom_range(0, 4) != 0)
      el = {2'($urandom), 6'($urandom_range(0, npos - 1))};
    case ($urandom_range(0, 4))
      0:       send_word(wtnm_pkg::CMD_HDR, ent, el, fill_value(), 8'($urandom), 3'($urandom));
      1, 2:    send_word(wtnm_pkg::CMD_TPL, ent, el, fill_value(), 8'($urandom), 3'($urandom));
      default: send_word(wtnm_pkg::CMD_QUERY, ent, el, fill_value(), 8'($urandom),
                         3'($urandom));
    endcase
  endtask

  // Write whatever the search would read that is still unwritten, then start it.
  task automatic run_search(bit pick, logic signed [wtnm_pkg::CountW-1:0] qc_given);
    int                                 lo;
    int                                 hi;
    int                                 npos;
    int                                 last_c;
    logic signed [wtnm_pkg::CountW-1:0] qc;
    lo   = int'(sb.first_r);
    hi   = sb.stop_entry();
    npos = sb.num_positions();
    for (int e = lo; e < hi; e++) begin
      if (!hdr_wr[e])
        send_word(wtnm_pkg::CMD_HDR, 6'(e), 8'($urandom), fill_value(), 8'($urandom),
                  3'($urandom));
    end
    qc = qc_given;
    if (pick) begin
      qc = 3'($urandom);
      if (hi > lo && $urandom_range(0, 3) != 0) qc = sb.cnt_mem[$urandom_range(lo, hi - 1)];
    end
    for (int e = lo; e < hi; e++) begin
      last_c = (sb.cnt_mem[e] >= 0 && sb.cnt_mem[e] == qc) ? int'(sb.cnt_mem[e]) : 0;
      for (int c = 0; c <= last_c; c++) begin
        for (int p = 0; p < npos; p++) begin
          if (!tpl_wr[e * 256 + c * 64 + p])
            send_word(wtnm_pkg::CMD_TPL, 6'(e), 8'(c * 64 + p), fill_value(), 8'($urandom),
                      3'($urandom));
          if (!qry_wr[c * 64 + p])
            send_word(wtnm_pkg::CMD_QUERY, 6'($urandom), 8'(c * 64 + p), fill_value(),
                      8'($urandom), 3'($urandom));
        end
      end
    end
    send_word(wtnm_pkg::CMD_RUN, 6'($urandom), 8'($urandom), 16'($urandom), 8'($urandom), qc);
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    int burst;
    int hold;
    burst       = 0;
    hold        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        sb.check({best_symbol_o, best_entry_o, found_o, distance_o});
      @(negedge clk_i);
      if (hold_req) begin
        hold     = 1500;
        hold_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (!calm && busy_phase && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(0, 4);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = wtnm_pkg::CMD_HDR;
    entry_i     = '0;
    elem_i      = '0;
    value_i     = '0;
    symbol_i    = '0;
    contours_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = wtnm_pkg::CFG_DESC_COUNT;
    cfg_data_i  = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: value extremes, every header kind, matched and skipped entries.
    set_regs(7'd1, 7'd0, 7'd4);
    send_word(wtnm_pkg::CMD_HDR, 6'd0, 8'd0, 16'sd0, 8'h41, -3'sd1);
    send_word(wtnm_pkg::CMD_HDR, 6'd1, 8'd0, 16'sd0, 8'hFF, 3'sd0);
    send_word(wtnm_pkg::CMD_HDR, 6'd2, 8'd0, 16'sd0, 8'h00, 3'sd3);
    send_word(wtnm_pkg::CMD_HDR, 6'd3, 8'd0, 16'sd0, 8'h80, 3'sb100);
    send_word(wtnm_pkg::CMD_TPL, 6'd0, 8'd0, 16'sh7FFF, 8'd0, 3'sd0);
    send_word(wtnm_pkg::CMD_TPL, 6'd0, 8'd1, 16'sh8000, 8'd0, 3'sd0);
    send_word(wtnm_pkg::CMD_TPL, 6'd1, 8'd0, 16'sh8000, 8'd0, 3'sd0);
    send_word(wtnm_pkg::CMD_TPL, 6'd1, 8'd1, 16'sh7FFF, 8'd0, 3'sd0);
    send_word(wtnm_pkg::CMD_QUERY, 6'd0, 8'd0, 16'sh8000, 8'd0, 3'sd0);
    send_word(wtnm_pkg::CMD_QUERY, 6'd0, 8'd1, 16'sh7FFF, 8'd0, 3'sd0);
    send_word(wtnm_pkg::CMD_HDR, 6'd63, 8'd0, 16'sd0, 8'h7E, 3'sd3);
    send_word(wtnm_pkg::CMD_TPL, 6'd63, 8'd255, 16'sh7FFF, 8'd0, 3'sd0);
    send_word(wtnm_pkg::CMD_QUERY, 6'd0, 8'd255, 16'sh8000, 8'd0, 3'sd0);
    run_search(1'b0, 3'sd0);
    run_search(1'b0, 3'sd3);
    run_search(1'b0, -3'sd2);

    for (int ph = 0; ph < NPH; ph++) begin
      busy_phase = (ph % 3 != 2);
      calm       = (ph >= NPH - 2);
      flat       = (ph == 8);
      set_regs(7'(PH_DESC[ph]), 7'(PH_FIRST[ph]), 7'(PH_END[ph]));
      if (ph == 5) cfg_write(wtnm_pkg::CFG_UNUSED, 7'($urandom));
      // fill the result register and then the search path behind it
      if (ph == 7) hold_req = 1'b1;
      for (int r = 0; r < PH_RUNS[ph]; r++) begin
        repeat ($urandom_range(1, 2)) noise_word();
        run_search(1'b1, 3'sd0);
      end
    end

    wait_idle();
    $display("Covered %0d load words and %0d searches (%0d with a qualifying entry)",
             loads, sb.searches, sb.hits);
    $display("over %0d register settings, including empty and saturated ranges.", NPH + 1);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
